### rtl/rmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants, types and the saturation helper of the rotation-matrix-to-quaternion core.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int DATA_W   = 16;
    localparam int FRAC     = 14;
    localparam int SUM_W    = DATA_W + 2;
    localparam int NUM_W    = DATA_W + 1;
    localparam int SQ_IN_W  = 2 * ((NUM_W + FRAC + 1) / 2);
    localparam int ROOT_W   = SQ_IN_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int S_W      = ROOT_W + 1;
    localparam int DIV_D_W  = NUM_W + FRAC;
    localparam int Q_BITS   = DIV_D_W - (FRAC / 2 + 1);
    localparam int DREM_W   = S_W + 1;
    localparam int LATENCY  = 2 + ROOT_W + Q_BITS;

    typedef enum logic [1:0] {
        AX_W = 2'd0,
        AX_X = 2'd1,
        AX_Y = 2'd2,
        AX_Z = 2'd3
    } t_axis;

    typedef struct packed {
        logic                        valid;
        t_axis                       axis;
        logic                        degen;
        logic [2:0][NUM_W-1:0]       n;
        logic [SQ_IN_W-1:0]          x;
        logic [ROOT_W-1:0]           root;
        logic [REM_W-1:0]            rem;
    } t_sq;

    typedef struct packed {
        logic                        valid;
        t_axis                       axis;
        logic                        degen;
        logic [ROOT_W-1:0]           root;
        logic [2:0]                  neg;
        logic [2:0][Q_BITS-1:0]      dlo;
        logic [2:0][DREM_W-1:0]      rem;
        logic [2:0][Q_BITS-1:0]      q;
    } t_dv;

    function automatic logic [DATA_W-1:0] sat_mag(input logic neg, input logic [Q_BITS-1:0] q);
        logic [Q_BITS:0] lim;
        logic [Q_BITS:0] qe;
        logic [Q_BITS:0] neg_q;
        qe    = {1'b0, q};
        lim   = (Q_BITS+1)'(1) << (DATA_W - 1);
        neg_q = -qe;
        if (!neg) begin
            sat_mag = (qe >= lim) ? DATA_W'(lim - 1'b1) : qe[DATA_W-1:0];
        end else begin
            sat_mag = (qe > lim) ? DATA_W'(lim) : neg_q[DATA_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

### rtl/rmq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_front
// Branch selection on trace and diagonal, radicand and numerator forming.
// ----------------------------------------------------------------------------
module rmq_front (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    input  wire [8:0][rmq_pkg::DATA_W-1:0] i_m,
    output rmq_pkg::t_sq              o_st
);

    logic signed [rmq_pkg::SUM_W-1:0] m [9];
    logic signed [rmq_pkg::SUM_W-1:0] trace;
    logic signed [rmq_pkg::SUM_W-1:0] rad;
    logic signed [rmq_pkg::SUM_W-1:0] one;
    rmq_pkg::t_sq n_st;
    rmq_pkg::t_sq r_st;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            m[i] = rmq_pkg::SUM_W'($signed(i_m[i]));
        end
        one   = rmq_pkg::SUM_W'(1) << rmq_pkg::FRAC;
        trace = m[0] + m[4] + m[8];
        n_st  = '0;
        n_st.valid = i_valid;
        if (trace > 0) begin
            n_st.axis = rmq_pkg::AX_W;
            rad = trace + one;
            n_st.n[0] = rmq_pkg::NUM_W'(m[7] - m[5]);
            n_st.n[1] = rmq_pkg::NUM_W'(m[2] - m[6]);
            n_st.n[2] = rmq_pkg::NUM_W'(m[3] - m[1]);
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            n_st.axis = rmq_pkg::AX_X;
            rad = one + m[0] - m[4] - m[8];
            n_st.n[0] = rmq_pkg::NUM_W'(m[7] - m[5]);
            n_st.n[1] = rmq_pkg::NUM_W'(m[1] + m[3]);
            n_st.n[2] = rmq_pkg::NUM_W'(m[2] + m[6]);
        end else if (m[4] > m[8]) begin
            n_st.axis = rmq_pkg::AX_Y;
            rad = one + m[4] - m[0] - m[8];
            n_st.n[0] = rmq_pkg::NUM_W'(m[2] - m[6]);
            n_st.n[1] = rmq_pkg::NUM_W'(m[1] + m[3]);
            n_st.n[2] = rmq_pkg::NUM_W'(m[5] + m[7]);
        end else begin
            n_st.axis = rmq_pkg::AX_Z;
            rad = one + m[8] - m[0] - m[4];
            n_st.n[0] = rmq_pkg::NUM_W'(m[3] - m[1]);
            n_st.n[1] = rmq_pkg::NUM_W'(m[2] + m[6]);
            n_st.n[2] = rmq_pkg::NUM_W'(m[5] + m[7]);
        end
        n_st.degen = (rad <= 0);
        // radicand scaled up by the fraction bits so the root keeps the format
        n_st.x = n_st.degen ? '0 :
            rmq_pkg::SQ_IN_W'({rad[rmq_pkg::SUM_W-2:0], {rmq_pkg::FRAC{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.valid <= 1'b0;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule
`default_nettype wire

### rtl/rmq_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  rmq_pkg::t_sq i_st,
    output rmq_pkg::t_sq o_st
);

    localparam int N = rmq_pkg::ROOT_W;

    rmq_pkg::t_sq r_st [N];
    rmq_pkg::t_sq n_st [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [rmq_pkg::REM_W+1:0] tmp;
        logic [rmq_pkg::REM_W+1:0] trial;
        rmq_pkg::t_sq              src;

        if (g == 0) begin : g_first
            assign src = i_st;
        end else begin : g_next
            assign src = r_st[g-1];
        end

        always_comb begin
            n_st[g] = src;
            tmp     = {src.rem, src.x[rmq_pkg::SQ_IN_W-1 -: 2]};
            trial   = (rmq_pkg::REM_W+2)'({src.root, 2'b01});
            n_st[g].x = src.x << 2;
            if (tmp >= trial) begin
                n_st[g].rem  = rmq_pkg::REM_W'(tmp - trial);
                n_st[g].root = {src.root[rmq_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_st[g].rem  = tmp[rmq_pkg::REM_W-1:0];
                n_st[g].root = {src.root[rmq_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[g].valid <= 1'b0;
            end else begin
                r_st[g] <= n_st[g];
            end
        end
    end

    assign o_st = r_st[N-1];

endmodule
`default_nettype wire

### rtl/rmq_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider, rounded numerator over twice the root.
// ----------------------------------------------------------------------------
module rmq_div (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  rmq_pkg::t_sq i_st,
    output rmq_pkg::t_dv o_dv
);

    localparam int N = rmq_pkg::Q_BITS;

    rmq_pkg::t_dv r_dv [N];
    rmq_pkg::t_dv n_dv [N];
    rmq_pkg::t_dv entry;

    // dividend is |n| * 2^frac + root, the root being half the divisor
    always_comb begin
        logic [rmq_pkg::NUM_W-1:0]   mag;
        logic [rmq_pkg::DIV_D_W-1:0] d;
        entry       = '0;
        entry.valid = i_st.valid;
        entry.axis  = i_st.axis;
        entry.degen = i_st.degen;
        entry.root  = i_st.root;
        for (int l = 0; l < 3; l++) begin
            entry.neg[l] = i_st.n[l][rmq_pkg::NUM_W-1];
            mag = entry.neg[l] ? -i_st.n[l] : i_st.n[l];
            d   = {mag, {rmq_pkg::FRAC{1'b0}}} + rmq_pkg::DIV_D_W'(i_st.root);
            entry.rem[l] = rmq_pkg::DREM_W'(d[rmq_pkg::DIV_D_W-1:N]);
            entry.dlo[l] = d[N-1:0];
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        rmq_pkg::t_dv src;
        logic [rmq_pkg::S_W-1:0] dvs;
        logic [rmq_pkg::DREM_W-1:0] t [3];

        if (g == 0) begin : g_first
            assign src = entry;
        end else begin : g_next
            assign src = r_dv[g-1];
        end
        assign dvs = {src.root, 1'b0};

        always_comb begin
            n_dv[g] = src;
            for (int l = 0; l < 3; l++) begin
                t[l] = {src.rem[l][rmq_pkg::DREM_W-2:0], src.dlo[l][N-1]};
                n_dv[g].dlo[l] = src.dlo[l] << 1;
                if (t[l] >= rmq_pkg::DREM_W'(dvs)) begin
                    n_dv[g].rem[l] = t[l] - rmq_pkg::DREM_W'(dvs);
                    n_dv[g].q[l]   = {src.q[l][N-2:0], 1'b1};
                end else begin
                    n_dv[g].rem[l] = t[l];
                    n_dv[g].q[l]   = {src.q[l][N-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[g].valid <= 1'b0;
            end else begin
                r_dv[g] <= n_dv[g];
            end
        end
    end

    assign o_dv = r_dv[N-1];

endmodule
`default_nettype wire

### rtl/rmq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_back
// Sign, saturation, component placement and the output register.
// ----------------------------------------------------------------------------
module rmq_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  rmq_pkg::t_dv                i_dv,
    output logic                        o_strobe,
    output logic [rmq_pkg::DATA_W-1:0]  o_q_w,
    output logic [rmq_pkg::DATA_W-1:0]  o_q_x,
    output logic [rmq_pkg::DATA_W-1:0]  o_q_y,
    output logic [rmq_pkg::DATA_W-1:0]  o_q_z,
    output logic                        o_degenerate
);

    logic [rmq_pkg::DATA_W-1:0] c [3];
    logic [rmq_pkg::DATA_W-1:0] h;
    logic [rmq_pkg::DATA_W-1:0] n_q_w, n_q_x, n_q_y, n_q_z;
    logic [rmq_pkg::DATA_W-1:0] r_q_w, r_q_x, r_q_y, r_q_z;
    logic                       r_strobe, r_degen;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            c[l] = rmq_pkg::sat_mag(i_dv.neg[l], i_dv.q[l]);
        end
        // axis component is the root halved, rounded half up
        h = rmq_pkg::DATA_W'(({1'b0, i_dv.root} + 1'b1) >> 1);
        n_q_w = c[0];
        n_q_x = c[1];
        n_q_y = c[2];
        n_q_z = c[2];
        case (i_dv.axis)
            rmq_pkg::AX_W: begin
                n_q_w = h;    n_q_x = c[0]; n_q_y = c[1]; n_q_z = c[2];
            end
            rmq_pkg::AX_X: begin
                n_q_w = c[0]; n_q_x = h;    n_q_y = c[1]; n_q_z = c[2];
            end
            rmq_pkg::AX_Y: begin
                n_q_w = c[0]; n_q_x = c[1]; n_q_y = h;    n_q_z = c[2];
            end
            rmq_pkg::AX_Z: begin
                n_q_w = c[0]; n_q_x = c[1]; n_q_y = c[2]; n_q_z = h;
            end
            default: begin
                n_q_w = '0;   n_q_x = '0;   n_q_y = '0;   n_q_z = '0;
            end
        endcase
        if (i_dv.degen) begin
            n_q_w = '0; n_q_x = '0; n_q_y = '0; n_q_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_dv.valid;
        end
        r_q_w   <= n_q_w;
        r_q_x   <= n_q_x;
        r_q_y   <= n_q_y;
        r_q_z   <= n_q_z;
        r_degen <= i_dv.degen;
    end

    assign o_strobe     = r_strobe;
    assign o_q_w        = r_q_w;
    assign o_q_x        = r_q_x;
    assign o_q_y        = r_q_y;
    assign o_q_z        = r_q_z;
    assign o_degenerate = r_degen;

endmodule
`default_nettype wire

### rtl/rotation_matrix_to_quaternion_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Rotation matrix (Q2.14) to unit quaternion by Shepperd's branch method.
// ----------------------------------------------------------------------------
// A matrix is taken at every clock edge where start is high and busy is low;
// busy is low whenever reset is released, so one matrix per cycle. Each
// matrix gives one result, shown for one cycle with o_strobe; the receiver
// cannot stall. The result passes through the root pipeline (16 stages, one
// root bit each) and the three-lane divider (23 stages, one quotient bit
// each), plus one input and one output stage.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire  [rmq_pkg::DATA_W-1:0] i_m00,
    input  wire  [rmq_pkg::DATA_W-1:0] i_m01,
    input  wire  [rmq_pkg::DATA_W-1:0] i_m02,
    input  wire  [rmq_pkg::DATA_W-1:0] i_m10,
    input  wire  [rmq_pkg::DATA_W-1:0] i_m11,
    input  wire  [rmq_pkg::DATA_W-1:0] i_m12,
    input  wire  [rmq_pkg::DATA_W-1:0] i_m20,
    input  wire  [rmq_pkg::DATA_W-1:0] i_m21,
    input  wire  [rmq_pkg::DATA_W-1:0] i_m22,
    output logic                       o_strobe,
    output logic [rmq_pkg::DATA_W-1:0] o_q_w,
    output logic [rmq_pkg::DATA_W-1:0] o_q_x,
    output logic [rmq_pkg::DATA_W-1:0] o_q_y,
    output logic [rmq_pkg::DATA_W-1:0] o_q_z,
    output logic                       o_degenerate
);

    logic [8:0][rmq_pkg::DATA_W-1:0] m;
    rmq_pkg::t_sq front_st;
    rmq_pkg::t_sq sqrt_st;
    rmq_pkg::t_dv div_dv;

    // items are refused only while reset is applied
    assign busy = !i_rst_n;
    assign m = {i_m22, i_m21, i_m20, i_m12, i_m11, i_m10, i_m02, i_m01, i_m00};

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_m     (m),
        .o_st    (front_st)
    );

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (front_st),
        .o_st    (sqrt_st)
    );

    rmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (sqrt_st),
        .o_dv    (div_dv)
    );

    rmq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dv         (div_dv),
        .o_strobe     (o_strobe),
        .o_q_w        (o_q_w),
        .o_q_x        (o_q_x),
        .o_q_y        (o_q_y),
        .o_q_z        (o_q_z),
        .o_degenerate (o_degenerate)
    );

endmodule
`default_nettype wire

### rtl/rmq_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_check
// Port-level checks of the quaternion core, bound to the top level.
// ----------------------------------------------------------------------------
module rmq_check (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        start,
    input wire                        busy,
    input wire                        o_strobe,
    input wire [rmq_pkg::DATA_W-1:0]  o_q_w,
    input wire [rmq_pkg::DATA_W-1:0]  o_q_x,
    input wire [rmq_pkg::DATA_W-1:0]  o_q_y,
    input wire [rmq_pkg::DATA_W-1:0]  o_q_z,
    input wire                        o_degenerate
);

    // every result traces back to an item that the core accepted earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, rmq_pkg::LATENCY))
        else $error("result without matching item");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_degenerate) |->
            (o_q_w == '0 && o_q_x == '0 && o_q_y == '0 && o_q_z == '0))
        else $error("degenerate result not zero");

    a_no_busy: assert property (@(posedge i_clk)
        i_rst_n |-> !busy)
        else $error("busy outside reset");

    // axis component is a halved root, never negative
    a_nonneg_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_degenerate) |->
            (!o_q_w[rmq_pkg::DATA_W-1] || !o_q_x[rmq_pkg::DATA_W-1] ||
             !o_q_y[rmq_pkg::DATA_W-1] || !o_q_z[rmq_pkg::DATA_W-1]))
        else $error("no non-negative component");

endmodule

bind rotation_matrix_to_quaternion_core rmq_check u_rmq_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_q_w        (o_q_w),
    .o_q_x        (o_q_x),
    .o_q_y        (o_q_y),
    .o_q_z        (o_q_z),
    .o_degenerate (o_degenerate)
);
`default_nettype wire
